@@ design/knos_pkg.sv @@
// ---------------------------------------------------------------------------
// knos_pkg
// shared types and constants for the k-nearest-to-origin select unit
// ---------------------------------------------------------------------------
package knos_pkg;

    localparam int COORD_W    = 16;
    localparam int DIST_W     = 32;
    localparam int KCOUNT_W   = 5;
    localparam int K_MAX_DEF  = 16;
    localparam int COORD_BITS_DEF = 16;

    // one input transfer
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last_point;
    } t_in;

    // one result transfer
    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic [DIST_W-1:0]         out_distance;
        logic                      last_result;
    } t_out;

    // one kept point
    typedef struct packed {
        logic [DIST_W-1:0]         distance;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_entry;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic ins;
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

@@ design/knos_cell.sv @@
// ---------------------------------------------------------------------------
// knos_cell
// one slot of the sorted insertion chain: holds one point and its distance
// ---------------------------------------------------------------------------
module knos_cell
    import knos_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_new,
    input  t_entry     i_prev_entry,
    input  logic       i_prev_valid,
    input  logic       i_prev_disp,
    input  t_entry     i_next_entry,
    input  logic       i_next_valid,
    output t_entry     o_entry,
    output logic       o_valid,
    output logic       o_disp
);

    t_entry r_entry, n_entry;
    logic   r_valid, n_valid;

    // a strictly smaller new distance pushes this slot down; ties keep the older point
    assign o_disp = !r_valid || (i_new.distance < r_entry.distance);

    // next slot contents
    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        priority if (i_ctrl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctrl.shift) begin
            n_entry = i_next_entry;
            n_valid = i_next_valid;
        end else if (i_ctrl.ins && o_disp) begin
            if (i_prev_disp) begin
                n_entry = i_prev_entry;
                n_valid = i_prev_valid;
            end else begin
                n_entry = i_new;
                n_valid = 1'b1;
            end
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

@@ design/k_nearest_to_origin_select_unit.sv @@
// ---------------------------------------------------------------------------
// k_nearest_to_origin_select_unit
// keeps the k points closest to the origin in a sorted chain of cells and
// sends them out in ascending distance order when the run ends
// ---------------------------------------------------------------------------
//  channel   ports                        handshake
//  input     i_in (t_in)                  start high, busy low
//  result    o_out (t_out)                o_strobe for one cycle
//  config    i_cfg_wdata (k_count)        i_cfg_we
//
//  a point's squares are registered, then the sum is
//  compared against every cell at once and inserted into the chain
//  a point without the last flag lets the next one follow in the next cycle
//  a last point holds busy until min(k, points kept) results are sent: one result a
//  cycle is shifted out of the head cell, and the final one clears the chain
//  synchronous active-low reset empties the chain and sets k_count to 1
//  the receiver cannot stall the result strobe
// ---------------------------------------------------------------------------
module k_nearest_to_origin_select_unit
    import knos_pkg::*;
#(
    parameter int K_MAX      = K_MAX_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  t_in                 i_in,
    input  logic                i_cfg_we,
    input  logic [KCOUNT_W-1:0] i_cfg_wdata,
    output logic                o_strobe,
    output t_out                o_out
);

    localparam int KW = $clog2(K_MAX + 1);
    localparam int SH = COORD_W - COORD_BITS;

    logic                        w_accept;
    logic signed [COORD_W-1:0]   w_sx, w_sy;
    logic signed [2*COORD_W-1:0] w_xx, w_yy;

    logic                      r_s1_valid, r_s1_last;
    logic signed [COORD_W-1:0] r_s1_x, r_s1_y;
    logic [DIST_W-1:0]         r_s1_xx, r_s1_yy;

    logic [KCOUNT_W-1:0]       r_k_count;
    logic                      r_emitting;
    logic [KW-1:0]             r_left;
    logic [KW-1:0]             w_k_clamped;
    logic [6:0]                w_k_ext;
    logic                      w_emit_last;

    t_entry                    w_new;
    t_cell_ctrl                w_ctrl;
    t_entry                    w_entry [K_MAX+1];
    logic [K_MAX:0]            w_valid;
    logic [K_MAX:0]            w_disp;

    t_out                      r_out;
    logic                      r_strobe;

    assign busy     = r_emitting || (r_s1_valid && r_s1_last);
    assign w_accept = start && !busy;

    // take the low coordinate bits as two's complement
    assign w_sx = $signed(i_in.x << SH) >>> SH;
    assign w_sy = $signed(i_in.y << SH) >>> SH;

    // full-width squares
    assign w_xx = w_sx * w_sx;
    assign w_yy = w_sy * w_sy;

    // square stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_s1_last  <= w_accept && i_in.last_point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_x  <= w_sx;
            r_s1_y  <= w_sy;
            r_s1_xx <= DIST_W'($unsigned(w_xx));
            r_s1_yy <= DIST_W'($unsigned(w_yy));
        end
    end

    // point presented to the chain
    always_comb begin
        w_new.x        = r_s1_x;
        w_new.y        = r_s1_y;
        w_new.distance = r_s1_xx + r_s1_yy;
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_count <= KCOUNT_W'(1);
        end else if (i_cfg_we) begin
            r_k_count <= i_cfg_wdata;
        end
    end

    // zero counts as one, large values saturate
    always_comb begin
        w_k_ext = 7'(r_k_count);
        priority if (w_k_ext == 7'd0) begin
            w_k_clamped = KW'(1);
        end else if (w_k_ext > 7'(K_MAX)) begin
            w_k_clamped = KW'(K_MAX);
        end else begin
            w_k_clamped = KW'(r_k_count);
        end
    end

    // final result when k is used up or the next cell is empty
    assign w_emit_last = (r_left == KW'(1)) || !w_valid[1];

    // chain command
    always_comb begin
        w_ctrl.ins   = r_s1_valid;
        w_ctrl.shift = r_emitting && !w_emit_last;
        w_ctrl.clear = r_emitting && w_emit_last;
    end

    // chain ends
    assign w_disp[0]      = 1'b0;
    assign w_valid[K_MAX] = 1'b0;
    assign w_entry[K_MAX] = w_new;

    // insertion chain
    for (genvar g = 0; g < K_MAX; g++) begin : g_cell
        t_entry w_prev_entry;
        logic   w_prev_valid;

        if (g == 0) begin : g_head
            assign w_prev_entry = w_new;
            assign w_prev_valid = 1'b0;
        end else begin : g_body
            assign w_prev_entry = w_entry[g-1];
            assign w_prev_valid = w_valid[g-1];
        end

        knos_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_new        (w_new),
            .i_prev_entry (w_prev_entry),
            .i_prev_valid (w_prev_valid),
            .i_prev_disp  (w_disp[g]),
            .i_next_entry (w_entry[g+1]),
            .i_next_valid (w_valid[g+1]),
            .o_entry      (w_entry[g]),
            .o_valid      (w_valid[g]),
            .o_disp       (w_disp[g+1])
        );
    end

    // emission control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emitting <= 1'b0;
            r_left     <= '0;
        end else if (r_emitting) begin
            r_left <= r_left - KW'(1);
            if (w_emit_last) begin
                r_emitting <= 1'b0;
            end
        end else if (r_s1_valid && r_s1_last) begin
            r_emitting <= 1'b1;
            r_left     <= w_k_clamped;
        end
    end

    // result register fed from the head cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_emitting;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_emitting) begin
            r_out.out_x        <= w_entry[0].x;
            r_out.out_y        <= w_entry[0].y;
            r_out.out_distance <= w_entry[0].distance;
            r_out.last_result  <= w_emit_last;
        end
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

`ifndef SYNTHESIS
    // kept points always form a prefix of the chain
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + (K_MAX+1)'(1)) & w_valid) == '0)
        else $error("valid cells do not form a prefix");

    // the head cell holds a point whenever a result is sent
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitting |-> w_valid[0])
        else $error("emission from an empty chain");

    // the chain is empty right after the final result of a run
    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.last_result) |-> (w_valid == '0))
        else $error("chain not cleared after final result");

    // a result strobe follows an emission cycle
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitting |=> o_strobe)
        else $error("emission cycle without result strobe");
`endif

endmodule
